// File: sv/pidaz_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PID controller with active zone and deadband.
// No dependencies; imported by the top level and by the bench.
package pidaz_pkg;

  localparam int VALUE_WIDTH_DEF = 24;   // default width of setpoint, measured and drive

  localparam int GAIN_W = 16;            // signed Q8.8 gains
  localparam int LP_W   = 8;             // loop period in ms
  localparam int AZ_W   = 24;            // active zone
  localparam int CAP_W  = 31;            // integral clamp
  localparam int DZ_W   = 16;            // deadband
  localparam int INT_W  = 32;            // integral store, |integral| <= 2^31-1
  localparam int CFG_W  = 31;            // widest register
  localparam int IDX_W  = 3;

  localparam logic [LP_W-1:0] LP_RESET = 8'd20;

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_LOOP_PERIOD  = 3'd4,
    REG_ACTIVE_ZONE  = 3'd5,
    REG_INTEGRAL_CAP = 3'd6,
    REG_DEAD_ZONE    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_ELP,
    S_GAIN,
    S_INTADD,
    S_INTCLAMP,
    S_ILP,
    S_SUM1,
    S_SUM2,
    S_ABS,
    S_ROUND,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

endpackage

// File: sv/pid_with_active_zone_and_deadband.sv
`timescale 1ns / 1ps
// PID controller with integral active zone, integral clamp and output deadband.
// Bit-serial multipliers and divider under one sequencer; uses pidaz_pkg.
//
//   channel  ports                           transfer when
//   -------  ------------------------------  --------------------------
//   input    in_valid/in_ready, in_setpoint,  in_valid & in_ready
//            in_measured
//   result   out_valid/out_ready, out_drive   out_valid & out_ready
//   config   cfg_we, cfg_index, cfg_wdata     cfg_we (no wait, no read-back)
//
// Flow: one item at a time; the next input is taken only once the result
// has gone to the output register. The serial divider makes one quotient
// bit a cycle over NQ bits, NQ = max(W+25,40)-5 for W = VALUE_WIDTH.
// Disabled items skip the datapath and give a drive of 0.
// Reset: synchronous, active low; clears registers, integral and last error.
// Stalls: a finished result waits in the output register; the next item is
// taken meanwhile, and only the final hand-over step waits on out_ready.
module pid_with_active_zone_and_deadband
  import pidaz_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_setpoint,
  input  logic signed [VALUE_WIDTH-1:0] in_measured,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_drive,
  input  logic                          cfg_we,
  input  logic [IDX_W-1:0]              cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata
);

  // Datapath widths, all following VALUE_WIDTH but ILW.
  localparam int EW    = VALUE_WIDTH + 1;           // error
  localparam int DW    = VALUE_WIDTH + 2;           // error difference
  localparam int ELW   = EW + LP_W;                 // error * loop period
  localparam int PW    = ELW + GAIN_W;              // gain * error * loop period
  localparam int PDW   = DW + GAIN_W;               // gain_d * error difference
  localparam int ISW   = PW + 1;                    // integral before clamping
  localparam int ILW   = INT_W + LP_W;              // integral * loop period
  localparam int NW    = ((PW > ILW) ? PW : ILW) + 2; // numerator over 256*lp
  localparam int NQ    = NW - 7;                    // dividend after the /256 step
  localparam int AZC_W = (EW > AZ_W) ? EW : AZ_W;
  localparam int CNT_W = $clog2(NQ);

  localparam logic [NQ-1:0] HI_MAG = NQ'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam logic [NQ-1:0] LO_MAG = NQ'(64'd1 << (VALUE_WIDTH - 1));

  // Configuration registers
  logic                     enable_r;
  logic signed [GAIN_W-1:0] gain_p_r;
  logic signed [GAIN_W-1:0] gain_i_r;
  logic signed [GAIN_W-1:0] gain_d_r;
  logic [LP_W-1:0]          loop_period_r;
  logic [AZ_W-1:0]          active_zone_r;
  logic [CAP_W-1:0]         integral_cap_r;
  logic [DZ_W-1:0]          dead_zone_r;

  // Sequencer
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             out_load;

  // Controller state
  logic signed [EW-1:0]    last_err_r;
  logic signed [INT_W-1:0] integral_r;

  // Working registers
  logic signed [EW-1:0]    err_r;
  logic signed [DW-1:0]    ediff_r;
  logic [EW-1:0]           err_abs_r;
  logic                    in_zone_r;
  logic [LP_W-1:0]         lp_sh_r;
  logic [GAIN_W-1:0]       gi_sh_r;
  logic [GAIN_W-1:0]       gp_sh_r;
  logic [GAIN_W-1:0]       gd_sh_r;
  logic signed [ELW-1:0]   elp_r;
  logic signed [PW-1:0]    pi_r;
  logic signed [PW-1:0]    pp_r;
  logic signed [PDW-1:0]   pd_r;
  logic signed [ISW-1:0]   isum_r;
  logic signed [ILW-1:0]   ilp_r;
  logic signed [NW-1:0]    sum_r;
  logic [NW-1:0]           mag_r;
  logic                    neg_r;
  logic [NQ-1:0]           dq_r;
  logic [LP_W-1:0]         rem_r;
  logic [VALUE_WIDTH-1:0]  res_r;
  logic                    out_valid_r;
  logic [VALUE_WIDTH-1:0]  out_drive_r;

  // Combinational datapath terms
  logic [LP_W-1:0]         lp_eff;
  logic                    gain_first;
  logic signed [PW-1:0]    elp_ext;
  logic signed [PW-1:0]    pi_add;
  logic signed [PW-1:0]    pp_add;
  logic signed [PDW-1:0]   ed_ext;
  logic signed [PDW-1:0]   pd_add;
  logic signed [ISW-1:0]   cap_s;
  logic signed [ISW-1:0]   cap_neg_s;
  logic [NW:0]             rnd_sum;
  logic [LP_W:0]           div_trial;
  logic                    div_ge;
  logic [VALUE_WIDTH-1:0]  fin_val;

  //--------------------------------------------------------------------------
  // Configuration writes; every index of the 3-bit port maps to a register.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      gain_p_r       <= '0;
      gain_i_r       <= '0;
      gain_d_r       <= '0;
      loop_period_r  <= LP_RESET;
      active_zone_r  <= '0;
      integral_cap_r <= '0;
      dead_zone_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_ENABLE:       enable_r       <= cfg_wdata[0];
        REG_GAIN_P:       gain_p_r       <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:       gain_i_r       <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:       gain_d_r       <= cfg_wdata[GAIN_W-1:0];
        REG_LOOP_PERIOD:  loop_period_r  <= cfg_wdata[LP_W-1:0];
        REG_ACTIVE_ZONE:  active_zone_r  <= cfg_wdata[AZ_W-1:0];
        REG_INTEGRAL_CAP: integral_cap_r <= cfg_wdata[CAP_W-1:0];
        REG_DEAD_ZONE:    dead_zone_r    <= cfg_wdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // A loop period of zero behaves as one.
  assign lp_eff = (loop_period_r == '0) ? LP_W'(1) : loop_period_r;

  //--------------------------------------------------------------------------
  // Next state
  //--------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = enable_r ? S_DIFF : S_DONE;   // disabled: drive 0 at once
        end
      end
      S_DIFF:     state_nxt = S_ELP;
      S_ELP:      if (cnt_r == '0) state_nxt = S_GAIN;
      S_GAIN:     if (cnt_r == '0) state_nxt = S_INTADD;
      S_INTADD:   state_nxt = S_INTCLAMP;
      S_INTCLAMP: state_nxt = S_ILP;
      S_ILP:      if (cnt_r == '0) state_nxt = S_SUM1;
      S_SUM1:     state_nxt = S_SUM2;
      S_SUM2:     state_nxt = S_ABS;
      S_ABS:      state_nxt = S_ROUND;
      S_ROUND:    state_nxt = S_DIV;
      S_DIV:      if (cnt_r == '0) state_nxt = S_FIN;
      S_FIN:      state_nxt = S_DONE;
      S_DONE:     if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  //--------------------------------------------------------------------------
  // Sequencer outputs: take an item only when idle; hand the result over as
  // soon as the output register is free or being emptied.
  //--------------------------------------------------------------------------
  always_comb begin
    in_ready = (state_r == S_IDLE);
    out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Reload the step counter on entry to each serial phase, else count down.
      case (state_r)
        S_DIFF:     cnt_r <= CNT_W'(LP_W - 1);
        S_ELP:      cnt_r <= (cnt_r == '0) ? CNT_W'(GAIN_W - 1) : cnt_r - CNT_W'(1);
        S_GAIN:     cnt_r <= (cnt_r == '0) ? '0 : cnt_r - CNT_W'(1);
        S_INTCLAMP: cnt_r <= CNT_W'(LP_W - 1);
        S_ILP:      cnt_r <= (cnt_r == '0) ? '0 : cnt_r - CNT_W'(1);
        S_ROUND:    cnt_r <= CNT_W'(NQ - 1);
        S_DIV:      cnt_r <= (cnt_r == '0) ? '0 : cnt_r - CNT_W'(1);
        default:    cnt_r <= cnt_r;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  //--------------------------------------------------------------------------
  // Serial multiplier lanes. Gains go MSB first (Horner form); the sign bit
  // of a Q8.8 gain weighs negative, so its partial product is subtracted.
  //--------------------------------------------------------------------------
  always_comb begin
    gain_first = (cnt_r == CNT_W'(GAIN_W - 1));
    elp_ext    = PW'(elp_r);
    ed_ext     = PDW'(ediff_r);
    pi_add = gi_sh_r[GAIN_W-1] ? (gain_first ? -elp_ext : elp_ext) : '0;
    pp_add = gp_sh_r[GAIN_W-1] ? (gain_first ? -elp_ext : elp_ext) : '0;
    pd_add = gd_sh_r[GAIN_W-1] ? (gain_first ? -ed_ext : ed_ext) : '0;
  end

  assign cap_s     = ISW'($signed({1'b0, integral_cap_r}));
  assign cap_neg_s = -cap_s;

  // Round half away from zero: floor((|num| + 128*lp) / 256) / lp, the /256
  // being a plain bit drop.
  assign rnd_sum = {1'b0, mag_r} + ((NW + 1)'(lp_eff) << 7);

  // Restoring divider step: one quotient bit per cycle, remainder below lp.
  assign div_trial = {rem_r, dq_r[NQ-1]};
  assign div_ge    = (div_trial >= {1'b0, lp_eff});

  // Deadband on the rounded magnitude, then saturate and apply the sign.
  always_comb begin
    if (dq_r < NQ'(dead_zone_r)) begin
      fin_val = '0;
    end else if (!neg_r) begin
      fin_val = (dq_r > HI_MAG) ? HI_MAG[VALUE_WIDTH-1:0] : dq_r[VALUE_WIDTH-1:0];
    end else begin
      fin_val = (dq_r > LO_MAG) ? LO_MAG[VALUE_WIDTH-1:0] : -dq_r[VALUE_WIDTH-1:0];
    end
  end

  //--------------------------------------------------------------------------
  // Controller state: last error advances once per enabled item; the integral
  // is replaced by its clamped update. Both hold while disabled.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      integral_r <= '0;
    end else begin
      if (state_r == S_DIFF) begin
        last_err_r <= err_r;
      end
      if (state_r == S_INTCLAMP) begin
        if (isum_r > cap_s) begin
          integral_r <= INT_W'(cap_s);
        end else if (isum_r < cap_neg_s) begin
          integral_r <= INT_W'(cap_neg_s);
        end else begin
          integral_r <= INT_W'(isum_r);
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Working datapath
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_r <= EW'(in_setpoint) - EW'(in_measured);
          res_r <= '0;
        end
      end
      S_DIFF: begin
        ediff_r   <= DW'(err_r) - DW'(last_err_r);
        err_abs_r <= err_r[EW-1] ? $unsigned(-err_r) : $unsigned(err_r);
        elp_r     <= '0;
        lp_sh_r   <= lp_eff;
      end
      S_ELP: begin
        elp_r   <= (elp_r <<< 1) + (lp_sh_r[LP_W-1] ? ELW'(err_r) : '0);
        lp_sh_r <= lp_sh_r << 1;
        if (cnt_r == '0) begin
          in_zone_r <= (AZC_W'(err_abs_r) <= AZC_W'(active_zone_r));
          gi_sh_r   <= gain_i_r;
          gp_sh_r   <= gain_p_r;
          gd_sh_r   <= gain_d_r;
          pi_r      <= '0;
          pp_r      <= '0;
          pd_r      <= '0;
        end
      end
      S_GAIN: begin
        pi_r    <= (pi_r <<< 1) + pi_add;
        pp_r    <= (pp_r <<< 1) + pp_add;
        pd_r    <= (pd_r <<< 1) + pd_add;
        gi_sh_r <= gi_sh_r << 1;
        gp_sh_r <= gp_sh_r << 1;
        gd_sh_r <= gd_sh_r << 1;
      end
      S_INTADD: begin
        // Outside the active zone the integral drops to zero.
        isum_r <= in_zone_r ? (ISW'(integral_r) + ISW'(pi_r)) : '0;
      end
      S_INTCLAMP: begin
        ilp_r   <= '0;
        lp_sh_r <= lp_eff;
      end
      S_ILP: begin
        ilp_r   <= (ilp_r <<< 1) + (lp_sh_r[LP_W-1] ? ILW'(integral_r) : '0);
        lp_sh_r <= lp_sh_r << 1;
      end
      S_SUM1: begin
        sum_r <= NW'(pp_r) + NW'(pd_r);
      end
      S_SUM2: begin
        sum_r <= sum_r + NW'(ilp_r);
      end
      S_ABS: begin
        neg_r <= sum_r[NW-1];
        mag_r <= sum_r[NW-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
      end
      S_ROUND: begin
        dq_r  <= rnd_sum[NW:8];
        rem_r <= '0;
      end
      S_DIV: begin
        rem_r <= div_ge ? LP_W'(div_trial - {1'b0, lp_eff}) : div_trial[LP_W-1:0];
        dq_r  <= {dq_r[NQ-2:0], div_ge};
      end
      S_FIN: begin
        res_r <= fin_val;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/pidaz_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the PID controller top level, and its bind.
// Depends on pid_with_active_zone_and_deadband only through the bind.
module pidaz_chk #(
  parameter int VALUE_WIDTH = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_drive
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // One item at a time: a transfer in makes the block busy on the next cycle.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
      (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  // A fresh result only comes from the busy hand-over step.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
      $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_drive)))
    else $error("stalled result dropped or changed");

endmodule

bind pid_with_active_zone_and_deadband pidaz_chk #(.VALUE_WIDTH(VALUE_WIDTH)) u_pidaz_chk (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for pid_with_active_zone_and_deadband: drives setpoint/measured pairs,
// predicts each drive value in fixed point and compares it with every output transfer.
// Depends on pidaz_pkg and the controller top level only.
module tb_top;
  import pidaz_pkg::*;

  localparam int VW          = VALUE_WIDTH_DEF;
  localparam int QUIET_LIMIT = 4000;   // cycles with no transfer before the run is abandoned
  localparam int HOLD_CYCLES = 400;    // long output hold-off, well past one item's latency

  localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    logic signed [VW-1:0] sp;
    logic signed [VW-1:0] ms;
  } sample_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Block ports; the inputs are known from time zero
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [VW-1:0] in_setpoint = '0;
  logic signed [VW-1:0] in_measured = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [VW-1:0] out_drive;
  logic                 cfg_we = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  pid_with_active_zone_and_deadband #(
    .VALUE_WIDTH(VW)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_setpoint (in_setpoint),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_drive   (out_drive),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  // Shadow copy of the register file, at reset values
  logic                   en_sh   = 1'b0;
  logic signed [15:0]     kp_sh   = '0;
  logic signed [15:0]     ki_sh   = '0;
  logic signed [15:0]     kd_sh   = '0;
  logic [LP_W-1:0]        lp_sh   = LP_RESET;
  logic [AZ_W-1:0]        az_sh   = '0;
  logic [CAP_W-1:0]       cap_sh  = '0;
  logic [DZ_W-1:0]        dz_sh   = '0;

  // Controller state as the predictor sees it
  longint integ_acc = 0;
  longint prev_err  = 0;

  sample_t              pending_q[$];   // pairs waiting to be offered
  logic signed [VW-1:0] drive_q[$];     // drive values still owed by the block

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int send_gap      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  int quiet         = 0;
  int errors        = 0;
  int items_taken   = 0;
  int drives_seen   = 0;
  int settings_used = 0;
  sample_t              next_pair;
  logic signed [VW-1:0] want;

  // Advance the controller by one sample and return the drive value it owes.
  // The whole sum is kept over the common denominator 256*period, so no
  // intermediate rounding creeps in before the final half-away-from-zero step.
  function automatic logic signed [VW-1:0] pid_drive_next(logic signed [VW-1:0] sp,
                                                          logic signed [VW-1:0] ms);
    longint err, lp, num, den, mag, rnd, hi, lo;
    if (!en_sh) return '0;              // disabled: drive 0, state untouched
    hi  = (longint'(1) <<< (VW - 1)) - 1;
    lo  = -hi - 1;
    err = longint'(sp) - longint'(ms);
    lp  = (lp_sh == 0) ? 1 : longint'(lp_sh);
    if (((err < 0) ? -err : err) <= longint'(az_sh)) begin
      integ_acc += longint'(ki_sh) * err * lp;
      if (integ_acc > longint'(cap_sh))
        integ_acc = longint'(cap_sh);
      else if (integ_acc < -longint'(cap_sh))
        integ_acc = -longint'(cap_sh);
    end else begin
      integ_acc = 0;                    // outside the active zone: drop the integral
    end
    num = longint'(kp_sh) * err * lp + integ_acc * lp + longint'(kd_sh) * (err - prev_err);
    den = 256 * lp;
    mag = (num < 0) ? -num : num;
    mag = (2 * mag + den) / (2 * den);
    rnd = (num < 0) ? -mag : mag;
    // Deadband looks at the rounded value before it is saturated
    if (((rnd < 0) ? -rnd : rnd) < longint'(dz_sh)) rnd = 0;
    if (rnd > hi) rnd = hi;
    else if (rnd < lo) rnd = lo;
    prev_err = err;
    return rnd[VW-1:0];
  endfunction

  // Driver: offer the next pending pair, predicting at each input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        drive_q.push_back(pid_drive_next(in_setpoint, in_measured));
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          // idle burst: this cycle, then send_gap more
          send_gap = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          next_pair = pending_q.pop_front();
          in_valid    <= 1'b1;
          in_setpoint <= next_pair.sp;
          in_measured <= next_pair.ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transfer, then decide whether to stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        drives_seen++;
        if (drive_q.size() == 0) begin
          $error("drive: unexpected transfer, expected none, got %0d", out_drive);
          errors++;
        end else begin
          want = drive_q.pop_front();
          if (out_drive !== want) begin
            $error("drive mismatch: expected %0d, got %0d", want, out_drive);
            errors++;
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: abandon the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("** pid_with_active_zone_and_deadband: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ENABLE:       en_sh  = val[0];
      REG_GAIN_P:       kp_sh  = val[15:0];
      REG_GAIN_I:       ki_sh  = val[15:0];
      REG_GAIN_D:       kd_sh  = val[15:0];
      REG_LOOP_PERIOD:  lp_sh  = val[LP_W-1:0];
      REG_ACTIVE_ZONE:  az_sh  = val[AZ_W-1:0];
      REG_INTEGRAL_CAP: cap_sh = val[CAP_W-1:0];
      REG_DEAD_ZONE:    dz_sh  = val[DZ_W-1:0];
      default: ;
    endcase
  endtask

  // Write the whole register file; only called with the block idle
  task automatic apply_settings(logic en, logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                                logic [LP_W-1:0] lp, logic [AZ_W-1:0] az,
                                logic [CAP_W-1:0] cap, logic [DZ_W-1:0] dz);
    write_reg(REG_ENABLE, CFG_W'(en));
    write_reg(REG_GAIN_P, CFG_W'(kp));
    write_reg(REG_GAIN_I, CFG_W'(ki));
    write_reg(REG_GAIN_D, CFG_W'(kd));
    write_reg(REG_LOOP_PERIOD, CFG_W'(lp));
    write_reg(REG_ACTIVE_ZONE, CFG_W'(az));
    write_reg(REG_INTEGRAL_CAP, CFG_W'(cap));
    write_reg(REG_DEAD_ZONE, CFG_W'(dz));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic push_pair(logic signed [VW-1:0] sp, logic signed [VW-1:0] ms);
    sample_t s;
    s.sp = sp;
    s.ms = ms;
    pending_q.push_back(s);
  endtask

  // Hold until every queued pair is in and every owed drive has come out
  task automatic wait_drained();
    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || drive_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [15:0] gain_pick();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3, 4:    return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_settings();
    logic            en;
    logic [15:0]     kp, ki, kd;
    logic [LP_W-1:0] lp;
    logic [AZ_W-1:0] az;
    logic [CAP_W-1:0] cap;
    logic [DZ_W-1:0] dz;
    en = ($urandom_range(0, 7) != 0);
    kp = gain_pick();
    ki = gain_pick();
    kd = gain_pick();
    case ($urandom_range(0, 4))
      0:       lp = '0;
      1:       lp = 8'd1;
      2:       lp = 8'd255;
      default: lp = LP_W'($urandom_range(1, 255));
    endcase
    case ($urandom_range(0, 4))
      0:       az = '0;
      1:       az = '1;
      2, 3:    az = AZ_W'($urandom_range(0, 4096));
      default: az = AZ_W'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       cap = '0;
      1:       cap = '1;
      2, 3:    cap = CAP_W'($urandom_range(0, 1 << 20));
      default: cap = CAP_W'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       dz = '1;
      1:       dz = DZ_W'($urandom_range(0, 64));
      2:       dz = DZ_W'($urandom);
      default: dz = '0;
    endcase
    apply_settings(en, kp, ki, kd, lp, az, cap, dz);
  endtask

  // Mostly close-tracking pairs so the integral gets to build up,
  // with full-range noise and rail-to-rail extremes mixed in
  function automatic sample_t random_sample();
    sample_t s;
    int delta;
    delta = $urandom_range(0, 1) ? int'($urandom_range(0, 32)) - 16
                                 : int'($urandom_range(0, 4096)) - 2048;
    case ($urandom_range(0, 7))
      0, 1: begin
        s.sp = VW'($urandom);
        s.ms = VW'($urandom);
      end
      2: begin
        s.sp = $urandom_range(0, 1) ? V_MAX : V_MIN;
        s.ms = $urandom_range(0, 1) ? V_MAX : V_MIN;
      end
      default: begin
        s.ms = VW'($urandom);
        s.sp = VW'(s.ms + delta);
      end
    endcase
    return s;
  endfunction

  initial begin
    int idle_opts[4];
    idle_opts = '{0, 5, 15, 30};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, with some idling on both sides
    send_idle_pct = 10;
    recv_idle_pct = 10;

    // Straight out of reset the controller is off
    push_pair(24'sd1000, -24'sd5);
    push_pair(V_MAX, V_MIN);
    wait_drained();

    // Half proportional gain, period written as zero: checks rounding of halves
    // away from zero, saturation at the top rail and reaching the bottom rail
    apply_settings(1'b1, 16'h0080, '0, '0, '0, '0, '0, '0);
    push_pair('0, '0);
    push_pair(24'sd1, '0);
    push_pair(-24'sd1, '0);
    push_pair(24'sd3, '0);
    push_pair('0, 24'sd3);
    push_pair(V_MAX, V_MIN);
    push_pair(V_MIN, V_MAX);
    wait_drained();

    // Extreme gains, widest zone and cap, largest deadband: huge sums saturate,
    // then small pairs follow them
    apply_settings(1'b1, 16'h7fff, 16'h7fff, 16'h8000, 8'd255, '1, '1, '1);
    push_pair(V_MAX, V_MIN);
    push_pair(V_MAX, V_MIN);
    push_pair(V_MIN, V_MAX);
    push_pair('0, '0);
    push_pair(24'sd5, '0);
    wait_drained();

    // Narrow zone and small cap: clamp inside the zone, clear just outside it
    apply_settings(1'b1, 16'h8000, 16'h8000, 16'h7fff, 8'd1, 24'd100, 31'd1000, '0);
    push_pair(24'sd50, '0);
    push_pair(24'sd50, '0);
    push_pair('0, 24'sd100);
    push_pair(24'sd101, '0);
    push_pair('0, '0);
    wait_drained();

    // Switch off and on again: integral and last error must survive
    apply_settings(1'b0, 16'h8000, 16'h8000, 16'h7fff, 8'd1, 24'd100, 31'd1000, '0);
    push_pair(24'sd7, '0);
    push_pair(24'sd7, '0);
    wait_drained();
    apply_settings(1'b1, 16'h8000, 16'h8000, 16'h7fff, 8'd1, 24'd100, 31'd1000, '0);
    push_pair(24'sd7, '0);
    wait_drained();

    // Zero cap keeps the integral pinned at zero
    apply_settings(1'b1, 16'h0100, 16'h7fff, '0, 8'd20, '1, '0, '0);
    push_pair(24'sd10, '0);
    push_pair(24'sd20, '0);
    wait_drained();

    // Random part: sixteen settings of a hundred pairs each
    for (int ph = 0; ph < 16; ph++) begin
      random_settings();
      if (ph >= 14) begin
        // run out with no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = idle_opts[$urandom_range(0, 3)];
        recv_idle_pct = idle_opts[$urandom_range(0, 3)];
      end
      for (int k = 0; k < 100; k++) begin
        pending_q.push_back(random_sample());
        // pause the sender mid-phase until the block has caught up
        if (ph == 6 && k == 49) wait_drained();
      end
      // hold the output off long enough for the block to back up its input
      if (ph == 3) hold_req = HOLD_CYCLES;
      wait_drained();
    end

    repeat (100) @(posedge clk);
    $display("Ran %0d samples through %0d register settings, %0d drive values checked,",
             items_taken, settings_used, drives_seen);
    $display("with idle bursts on both sides, one long output hold-off and one sender pause.");
    if (errors == 0) begin
      $display("** pid_with_active_zone_and_deadband: PASSED **");
    end else begin
      $display("** pid_with_active_zone_and_deadband: FAILED **");
    end
    $finish;
  end

endmodule
